// ===== sv/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// wts_pkg: shared definitions for windowed timing statistics
// Stream widths, field offsets, sequencer codes and fixed constants.
// ----------------------------------------------------------------------------
package wts_pkg;

	// input transfer: entry_index, start_time, end_time
	localparam int ENTRY_W = 6;
	localparam int TIME_W  = 64;
	localparam int DUR_W   = 32;
	localparam int COUNT_W = 6;

	localparam int IN_BITS  = ENTRY_W + 2 * TIME_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = ENTRY_W + 3 * DUR_W + COUNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [DUR_W-1:0] DUR_SAT = '1;

	typedef logic [3:0] seq_state_t;

	localparam seq_state_t ST_CLEAR  = 4'd0;
	localparam seq_state_t ST_IDLE   = 4'd1;
	localparam seq_state_t ST_REDUCE = 4'd2;
	localparam seq_state_t ST_MUL_LO = 4'd3;
	localparam seq_state_t ST_MUL_HI = 4'd4;
	localparam seq_state_t ST_SAT    = 4'd5;
	localparam seq_state_t ST_WALK   = 4'd6;
	localparam seq_state_t ST_DIV    = 4'd7;
	localparam seq_state_t ST_DONE   = 4'd8;

endpackage

// ===== sv/windowed_timing_statistics.sv =====
// ----------------------------------------------------------------------------
// windowed_timing_statistics: per-entry sliding window min / max / mean
// Scales a tick interval to Q16.16 ms, pushes it into the entry's ring and
// reports the window statistics of that entry.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: one transfer per measurement (entry, start, end ticks).
//  m_* channel: one transfer per measurement (entry, min, max, mean, count).
//  cfg_* channel: writes ms_per_tick_scale (Q0.32); cfg_ready is always high.
// Steps per item, with n samples now held in the ring:
//  accept, index reduction (entry_index reduced below ENTRIES by repeated
//  subtraction), two passes through the one 32x32 multiplier, saturation and
//  ring write, ring walk over the n samples (one memory read per cycle),
//  one bit per cycle restoring divider, result load. s_tready is low for the
//  whole item.
// The result sits in an output register; a new item is accepted while it
// waits. If the previous result is still untaken when the next one is done,
// the sequencer holds in its final step until m_tready.
// Reset: the per-entry fill/pointer table is cleared one entry per cycle,
// with s_tready low. The scale register resets to zero.
// ----------------------------------------------------------------------------
module windowed_timing_statistics #(
	parameter int ENTRIES = 64,
	parameter int HISTORY = 63
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// [5:0] entry_index, [69:6] start_time, [133:70] end_time, rest zero
	input  logic [wts_pkg::IN_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [5:0] result_entry, [37:6] window_min, [69:38] window_max,
	// [101:70] window_mean, [107:102] sample_count, rest zero
	output logic [wts_pkg::OUT_W-1:0] m_tdata,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [31:0]              cfg_data
);
	import wts_pkg::*;

	localparam int EW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW   = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int CW   = $clog2(HISTORY + 1);
	localparam int MW   = PW + CW;
	localparam int SUMW = DUR_W + CW;
	localparam int DCW  = $clog2(SUMW + 1);
	localparam logic [10:0]    ENT_L    = 11'(ENTRIES);
	localparam logic [EW-1:0]  ENT_LAST = EW'(ENTRIES - 1);
	localparam logic [PW-1:0]  WP_LAST  = PW'(HISTORY - 1);
	localparam logic [CW-1:0]  HIST_C   = CW'(HISTORY);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(SUMW - 1);

	seq_state_t state_q;

	logic [31:0]        scale_q;
	logic [ENTRY_W-1:0] ent_q;
	logic [TIME_W-1:0]  ticks_q;
	logic [63:0]        prod_lo_q;
	logic [63:0]        prod_hi_q;
	logic [EW-1:0]      clr_q;
	logic [PW-1:0]      wp_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      idx_q;
	logic               rdv_q;
	logic [DUR_W-1:0]   hist_rd_q;
	logic [MW-1:0]      meta_rd_q;
	logic [DUR_W-1:0]   min_q;
	logic [DUR_W-1:0]   max_q;
	logic [SUMW-1:0]    quo_q;
	logic [CW-1:0]      rem_q;
	logic [DCW-1:0]     div_cnt_q;

	logic               out_valid_q;
	logic [ENTRY_W-1:0] out_entry_q;
	logic [DUR_W-1:0]   out_min_q;
	logic [DUR_W-1:0]   out_max_q;
	logic [DUR_W-1:0]   out_mean_q;
	logic [COUNT_W-1:0] out_count_q;

	logic [31:0]         hist_mem [ENTRIES][HISTORY];
	logic [MW-1:0]       meta_mem [ENTRIES];

	logic [EW-1:0]       ent_idx;
	logic                in_xfer;
	logic                out_xfer;
	logic                out_load;
	logic [31:0]         mul_a;
	logic [63:0]         mul_p;
	logic [48:0]         dur_sum;
	logic [DUR_W-1:0]    dur;
	logic [PW-1:0]       old_wp;
	logic [CW-1:0]       old_fill;
	logic [PW-1:0]       new_wp;
	logic [CW-1:0]       new_fill;
	logic                meta_we;
	logic [EW-1:0]       meta_wa;
	logic [MW-1:0]       meta_wd;
	logic [CW:0]         trial;
	logic                trial_ge;

	assign ent_idx   = EW'(ent_q);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_xfer  = out_valid_q && m_tready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// shared multiplier: low word pass, then high word pass
	assign mul_a = (state_q == ST_MUL_LO) ? ticks_q[31:0] : ticks_q[63:32];
	assign mul_p = 64'(mul_a) * 64'(scale_q);

	// product >> 16 = hi << 16 + lo >> 16, saturating at 32 bits
	assign dur_sum = 49'({prod_hi_q[15:0], 16'd0}) + 49'(prod_lo_q[63:16]);
	assign dur = ((|prod_hi_q[63:16]) || (|dur_sum[48:32])) ? DUR_SAT : dur_sum[31:0];

	assign old_wp   = meta_rd_q[PW-1:0];
	assign old_fill = meta_rd_q[MW-1:PW];
	assign new_wp   = (old_wp >= WP_LAST) ? '0 : old_wp + 1'b1;
	assign new_fill = (old_fill < HIST_C) ? old_fill + 1'b1 : old_fill;

	always_comb begin
		meta_we = 1'b0;
		meta_wa = ent_idx;
		meta_wd = {new_fill, new_wp};
		if (state_q == ST_CLEAR) begin
			meta_we = 1'b1;
			meta_wa = clr_q;
			meta_wd = '0;
		end else if (state_q == ST_MUL_HI) begin
			meta_we = 1'b1;
		end
	end

	// restoring divider step
	assign trial    = {rem_q, quo_q[SUMW-1]};
	assign trial_ge = trial >= {1'b0, n_q};

	// per-entry fill count and write pointer
	always_ff @(posedge clk) begin
		if (meta_we)
			meta_mem[meta_wa] <= meta_wd;
		if (state_q == ST_MUL_LO)
			meta_rd_q <= meta_mem[ent_idx];
	end

	// duration rings
	always_ff @(posedge clk) begin
		if (state_q == ST_SAT)
			hist_mem[ent_idx][wp_q] <= dur;
		if (state_q == ST_WALK && idx_q != n_q)
			hist_rd_q <= hist_mem[ent_idx][idx_q[PW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ENT_LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_xfer)
						state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if ({5'd0, ent_q} < ENT_L)
						state_q <= ST_MUL_LO;
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_SAT;
				ST_SAT: begin
					rdv_q   <= 1'b0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					rdv_q <= (idx_q != n_q);
					if (idx_q == n_q && !rdv_q)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_LAST)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					ent_q   <= s_tdata[ENTRY_W-1:0];
					ticks_q <= s_tdata[ENTRY_W+2*TIME_W-1:ENTRY_W+TIME_W]
						- s_tdata[ENTRY_W+TIME_W-1:ENTRY_W];
				end
			end
			ST_REDUCE: begin
				if ({5'd0, ent_q} >= ENT_L)
					ent_q <= ent_q - ENT_L[ENTRY_W-1:0];
			end
			ST_MUL_LO: prod_lo_q <= mul_p;
			ST_MUL_HI: begin
				prod_hi_q <= mul_p;
				wp_q      <= (old_wp >= HIST_C[PW-1:0] && HISTORY > 1) ? '0 : old_wp;
				n_q       <= new_fill;
			end
			ST_SAT: begin
				idx_q <= '0;
				min_q <= DUR_SAT;
				max_q <= '0;
				quo_q <= '0;
			end
			ST_WALK: begin
				if (idx_q != n_q)
					idx_q <= idx_q + 1'b1;
				if (rdv_q) begin
					if (hist_rd_q < min_q)
						min_q <= hist_rd_q;
					if (hist_rd_q > max_q)
						max_q <= hist_rd_q;
					quo_q <= quo_q + SUMW'(hist_rd_q);
				end
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q     <= trial_ge ? CW'(trial - {1'b0, n_q}) : trial[CW-1:0];
				quo_q     <= {quo_q[SUMW-2:0], trial_ge};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_entry_q <= ent_q;
			out_min_q   <= min_q;
			out_max_q   <= max_q;
			out_mean_q  <= quo_q[DUR_W-1:0];
			out_count_q <= COUNT_W'(n_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_count_q, out_mean_q, out_max_q, out_min_q, out_entry_q});

	// one item at a time: no second accept right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// the window statistics are ordered
	a_stats_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_min_q <= out_mean_q) && (out_mean_q <= out_max_q))
		else $error("window min/mean/max out of order");

	// the walked count is a legal fill level
	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (n_q != '0) && (n_q <= HIST_C))
		else $error("ring fill count out of range during walk");

	// a result is never loaded over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && state_q == ST_DONE) |=> (state_q == ST_DONE))
		else $error("result register overwritten before transfer");

endmodule
